FILE: rtl/core/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg: I/O focus ring shared types
// Item structs, opcodes and fixed field widths of the focus ring manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifr_pkg;

  localparam int JOB_W     = 5;
  localparam int JOB_COUNT = 1 << JOB_W;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_SWITCH  = 2'd2;
  localparam logic [1:0] OP_FORCE   = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [JOB_W-1:0] job;
  } focus_in_t;

  typedef struct packed {
    logic [JOB_W-1:0] focus_job;
    logic             focus_valid;
    logic             focus_moved;
    logic [JOB_W-1:0] old_focus_job;
  } focus_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/ifr_ram.sv
// ----------------------------------------------------------------------------
// ifr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifr_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/ifr_seq.sv
// ----------------------------------------------------------------------------
// ifr_seq: focus ring sequencer
// Holds membership and focus, reads the link RAMs, updates and writes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifr_seq #(
  parameter int MAX_JOBS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ifr_pkg::focus_in_t cmd,
  input  wire logic               out_free,
  output logic                    busy,
  output logic                    done,
  output ifr_pkg::focus_out_t     result
);

  import ifr_pkg::*;

  localparam int SLOTS = (MAX_JOBS < JOB_COUNT) ? MAX_JOBS : JOB_COUNT;
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [JOB_W:0] LIMIT = (JOB_W + 1)'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LINK = 4'b0100,
    S_DONE = 4'b1000
  } seq_state_t;

  seq_state_t       state, state_next;
  logic [1:0]       op;
  logic [IDX_W-1:0] j;
  logic             j_ok;
  logic [SLOTS-1:0] member, member_next;
  logic [IDX_W-1:0] holder, holder_next;
  logic             holder_valid, holder_valid_next;
  logic [IDX_W-1:0] old_holder;
  logic             old_valid;
  logic [IDX_W-1:0] tail, tail_next;

  logic             nw_en, pw_en;
  logic [IDX_W-1:0] nw_addr, nw_data, pw_addr, pw_data;
  logic [IDX_W-1:0] nr_addr, pr_addr, nr_data, pr_data;
  logic             moved;

  ifr_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_next (
    .clk   (clk),
    .we    (nw_en),
    .waddr (nw_addr),
    .wdata (nw_data),
    .raddr (nr_addr),
    .rdata (nr_data)
  );

  ifr_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_prev (
    .clk   (clk),
    .we    (pw_en),
    .waddr (pw_addr),
    .wdata (pw_data),
    .raddr (pr_addr),
    .rdata (pr_data)
  );

  assign nr_addr = (cmd.opcode == OP_SWITCH)  ? holder : cmd.job[IDX_W-1:0];
  assign pr_addr = (cmd.opcode == OP_RELEASE) ? cmd.job[IDX_W-1:0] : holder;

  always_comb begin
    state_next        = state;
    member_next       = member;
    holder_next       = holder;
    holder_valid_next = holder_valid;
    tail_next         = tail;
    nw_en             = 1'b0;
    nw_addr           = j;
    nw_data           = j;
    pw_en             = 1'b0;
    pw_addr           = j;
    pw_data           = j;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (op)
          OP_REQUEST, OP_FORCE: begin
            if (j_ok) begin
              if (!member[j]) begin
                member_next[j] = 1'b1;
                nw_en          = 1'b1;
                pw_en          = 1'b1;
                if (!holder_valid) begin
                  holder_next       = j;
                  holder_valid_next = 1'b1;
                end else begin
                  pw_data    = pr_data;
                  nw_data    = holder;
                  tail_next  = pr_data;
                  state_next = S_LINK;
                end
              end
              if (op == OP_FORCE) begin
                holder_next = j;
              end
            end
          end
          OP_RELEASE: begin
            if (j_ok && member[j]) begin
              member_next[j] = 1'b0;
              if (nr_data != j) begin
                pw_en   = 1'b1;
                pw_addr = nr_data;
                pw_data = pr_data;
                nw_en   = 1'b1;
                nw_addr = pr_data;
                nw_data = nr_data;
                if (holder_valid && holder == j) begin
                  holder_next = nr_data;
                end
              end else begin
                holder_valid_next = 1'b0;
                holder_next       = '0;
              end
            end
          end
          OP_SWITCH: begin
            if (holder_valid) begin
              holder_next = nr_data;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_LINK: begin
        nw_en      = 1'b1;
        nw_addr    = tail;
        nw_data    = j;
        pw_en      = 1'b1;
        pw_addr    = old_holder;
        pw_data    = j;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      member       <= '0;
      holder       <= '0;
      holder_valid <= 1'b0;
    end else begin
      state        <= state_next;
      member       <= member_next;
      holder       <= holder_next;
      holder_valid <= holder_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tail <= tail_next;
    if (state == S_IDLE && start) begin
      op         <= cmd.opcode;
      j          <= cmd.job[IDX_W-1:0];
      j_ok       <= ({1'b0, cmd.job} < LIMIT);
      old_holder <= holder;
      old_valid  <= holder_valid;
    end
  end

  assign busy  = (state != S_IDLE);
  assign done  = (state == S_DONE);
  assign moved = old_valid && holder_valid && (holder != old_holder);

  assign result.focus_job     = holder_valid ? JOB_W'(holder) : '0;
  assign result.focus_valid   = holder_valid;
  assign result.focus_moved   = moved;
  assign result.old_focus_job = moved ? JOB_W'(old_holder) : '0;

endmodule

`default_nettype wire

FILE: rtl/core/io_focus_ring_manager.sv
// ----------------------------------------------------------------------------
// io_focus_ring_manager: I/O focus ring manager
// Keeps the ring of jobs asking for I/O focus and reports focus changes.
//
// Command channel cmd (cmd_valid / cmd_stall) carries an opcode and a job:
// request, release, switch to next, force focus. Every command gives exactly
// one item on the status channel stat (stat_valid / stat_stall): the focus
// holder after the command, whether focus moved between jobs, and the old
// holder.
// Ring links sit in two single-port-write RAMs (next and prev) with registered
// reads; membership and focus sit in flops.
// Each command passes the execute state and, for a request that links a job
// into a non-empty ring, a second link-write state on the link RAMs; from the
// done state its status item is loaded into the output register. One command
// is in flight at a time; cmd_stall stays high until its status item is loaded
// into the output register, so no new command is taken before then.
// Reset clears membership and focus; link RAM contents need no clearing.
// While stat_stall is high the status item holds; one more command may be
// taken, and its item then waits in the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module io_focus_ring_manager #(
  parameter int MAX_JOBS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire ifr_pkg::focus_in_t  cmd,
  output logic                     stat_valid,
  input  wire logic                stat_stall,
  output ifr_pkg::focus_out_t      stat
);

  import ifr_pkg::*;

  logic       busy;
  logic       done;
  logic       out_free;
  focus_out_t result;

  assign cmd_stall = busy;
  assign out_free  = !stat_valid || !stat_stall;

  ifr_seq #(.MAX_JOBS(MAX_JOBS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd_valid && !busy),
    .cmd      (cmd),
    .out_free (out_free),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= 1'b0;
    end else if (done && out_free) begin
      stat_valid <= 1'b1;
    end else if (!stat_stall) begin
      stat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      stat <= result;
    end
  end

endmodule

`default_nettype wire
